// File: hdl/stt_pkg.sv
// package for the source text tokenizer
// scan modes, result and token codes, character classes; no dependencies

package stt_pkg;

  localparam int OFFSET_BITS_DEF = 24;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_OP,
    MODE_TAB,
    MODE_EOL,
    MODE_NUM,
    MODE_STR,
    MODE_CHR,
    MODE_HALT
  } scan_mode_e;

  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_DONE  = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  localparam logic [2:0] TK_IDENT  = 3'd0;
  localparam logic [2:0] TK_OP     = 3'd1;
  localparam logic [2:0] TK_INDENT = 3'd2;
  localparam logic [2:0] TK_EOL    = 3'd3;
  localparam logic [2:0] TK_NUMBER = 3'd4;
  localparam logic [2:0] TK_STRING = 3'd5;
  localparam logic [2:0] TK_GROUP  = 3'd6;
  localparam logic [2:0] TK_CHAR   = 3'd7;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_FLOAT_DOT = 3'd2;
  localparam logic [2:0] ERR_OPEN_STR  = 3'd3;
  localparam logic [2:0] ERR_OPEN_CHR  = 3'd4;

  localparam logic [1:0] SUB_BASE = 2'd0;
  localparam logic [1:0] SUB_ONE  = 2'd1;
  localparam logic [1:0] SUB_TWO  = 2'd2;

  localparam logic REG_START_OFFSET = 1'b0;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_TILDE  = 8'h7e;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == CH_BANG || (c >= CH_HASH && c <= CH_AMP) ||
           (c >= CH_STAR && c <= CH_SLASH) || (c >= CH_COLON && c <= CH_AT) ||
           c == CH_CARET || c == CH_UNDER || c == CH_PIPE || c == CH_TILDE;
  endfunction

  function automatic logic is_group(input logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK ||
           c == CH_RBRACK || c == CH_LBRACE || c == CH_RBRACE;
  endfunction

endpackage

// File: hdl/stt_scan.sv
// scanner core: token state registers and the per-byte next-state logic
// produces up to two results per accepted byte; depends on stt_pkg

module stt_scan #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  localparam int ResW = 9 + 4 * OFFSET_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [7:0]             ch_i,
  input  logic                   cfg_we_i,
  input  logic [OFFSET_BITS-1:0] cfg_offset_i,
  output logic [ResW-1:0]        res0_o,
  output logic [ResW-1:0]        res1_o,
  output logic [1:0]             count_o
);
  import stt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] PosMax = {OFFSET_BITS{1'b1}};

  typedef struct packed {
    logic [OFFSET_BITS-1:0] column;
    logic [OFFSET_BITS-1:0] row;
    logic [2:0]             error_code;
    logic [OFFSET_BITS-1:0] end_pos;
    logic [OFFSET_BITS-1:0] begin_pos;
    logic [2:0]             token_kind;
    logic [1:0]             result_kind;
    logic                   last;
  } res_t;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  scan_mode_e             mode_q, mode_d;
  logic [1:0]             sub_q, sub_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] lcnt_q, lcnt_d;
  logic [OFFSET_BITS-1:0] lbeg_q, lbeg_d;

  logic                   redo;
  logic                   a_en, b_en;
  res_t                   a_res, b_res, r0, r1;
  logic [OFFSET_BITS-1:0] p, p_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      sub_q   <= SUB_BASE;
      start_q <= '0;
      pos_q   <= '0;
      lcnt_q  <= '0;
      lbeg_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      sub_q   <= sub_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      lcnt_q  <= lcnt_d;
      lbeg_q  <= lbeg_d;
    end
  end

  always_comb begin
    p       = pos_q;
    p_inc   = sat_inc(pos_q);
    mode_d  = mode_q;
    sub_d   = sub_q;
    start_d = start_q;
    pos_d   = pos_q;
    lcnt_d  = lcnt_q;
    lbeg_d  = lbeg_q;
    redo    = 1'b0;
    a_en    = 1'b0;
    b_en    = 1'b0;
    a_res   = '0;
    b_res   = '0;

    // closing emission: token or error of the token in progress
    a_res.begin_pos = start_q;
    a_res.end_pos   = p;

    if (valid_i) begin
      pos_d = p_inc;
      unique case (mode_q)
        MODE_HALT: begin
          pos_d = pos_q;
        end
        MODE_IDENT: begin
          if (!(is_alpha(ch_i) || is_digit(ch_i))) begin
            a_en = 1'b1;
            a_res.token_kind = TK_IDENT;
            redo = 1'b1;
          end
        end
        MODE_OP: begin
          if (!is_op(ch_i)) begin
            a_en = 1'b1;
            a_res.token_kind = TK_OP;
            redo = 1'b1;
          end
        end
        MODE_TAB: begin
          if (ch_i != CH_TAB) begin
            a_en = 1'b1;
            a_res.token_kind = TK_INDENT;
            redo = 1'b1;
          end
        end
        MODE_EOL: begin
          if (ch_i != CH_LF && ch_i != CH_CR) begin
            a_en = 1'b1;
            a_res.token_kind = TK_EOL;
            lbeg_d = p;
            lcnt_d = sat_inc(lcnt_q);
            redo = 1'b1;
          end
        end
        MODE_NUM: begin
          if (sub_q == SUB_BASE) begin
            if (ch_i == CH_DOT) begin
              sub_d = SUB_ONE;
            end else if (!is_digit(ch_i)) begin
              a_en = 1'b1;
              a_res.token_kind = TK_NUMBER;
              redo = 1'b1;
            end
          end else if (sub_q == SUB_ONE) begin
            if (is_digit(ch_i)) begin
              sub_d = SUB_TWO;
            end else begin
              a_en = 1'b1;
              a_res.result_kind = RK_ERROR;
              a_res.error_code = ERR_FLOAT_DOT;
            end
          end else if (!is_digit(ch_i)) begin
            a_en = 1'b1;
            a_res.token_kind = TK_NUMBER;
            redo = 1'b1;
          end
        end
        MODE_STR: begin
          if (sub_q == SUB_ONE) begin
            if (ch_i == CH_NUL) begin
              a_en = 1'b1;
              a_res.result_kind = RK_ERROR;
              a_res.error_code = ERR_OPEN_STR;
            end else begin
              sub_d = SUB_BASE;
            end
          end else if (ch_i == CH_DQUOTE) begin
            a_en = 1'b1;
            a_res.token_kind = TK_STRING;
            a_res.end_pos = p_inc;
            mode_d = MODE_IDLE;
          end else if (ch_i == CH_BSLASH) begin
            sub_d = SUB_ONE;
          end else if (ch_i == CH_LF || ch_i == CH_NUL) begin
            a_en = 1'b1;
            a_res.result_kind = RK_ERROR;
            a_res.error_code = ERR_OPEN_STR;
          end
        end
        MODE_CHR: begin
          if (ch_i == CH_NUL) begin
            a_en = 1'b1;
            a_res.result_kind = RK_ERROR;
            a_res.error_code = ERR_OPEN_CHR;
          end else if (sub_q == SUB_BASE && ch_i == CH_BSLASH) begin
            sub_d = SUB_ONE;
          end else begin
            a_en = 1'b1;
            a_res.token_kind = TK_CHAR;
            a_res.end_pos = p_inc;
            mode_d = MODE_IDLE;
            sub_d = SUB_BASE;
          end
        end
        default: begin
          redo = 1'b1;
        end
      endcase

      if (a_en && a_res.result_kind == RK_ERROR) begin
        a_res.row    = lcnt_q;
        a_res.column = start_q - lbeg_q;
        mode_d = MODE_HALT;
        sub_d  = SUB_BASE;
      end

      // start of the next token
      if (redo) begin
        start_d = p;
        sub_d   = SUB_BASE;
        mode_d  = MODE_IDLE;
        b_res.begin_pos = p;
        b_res.end_pos   = p;
        if (is_alpha(ch_i)) begin
          mode_d = MODE_IDENT;
        end else if (ch_i == CH_SPACE) begin
          mode_d = MODE_IDLE;
        end else if (is_op(ch_i)) begin
          mode_d = MODE_OP;
        end else if (ch_i == CH_TAB) begin
          mode_d = MODE_TAB;
        end else if (ch_i == CH_LF || ch_i == CH_CR) begin
          mode_d = MODE_EOL;
        end else if (is_digit(ch_i)) begin
          mode_d = MODE_NUM;
        end else if (ch_i == CH_DQUOTE) begin
          mode_d = MODE_STR;
        end else if (is_group(ch_i)) begin
          b_en = 1'b1;
          b_res.token_kind = TK_GROUP;
          b_res.end_pos = p_inc;
        end else if (ch_i == CH_SQUOTE) begin
          mode_d = MODE_CHR;
        end else if (ch_i == CH_NUL) begin
          b_en = 1'b1;
          b_res.result_kind = RK_DONE;
          b_res.begin_pos = '0;
          b_res.end_pos = '0;
          mode_d = MODE_HALT;
        end else begin
          b_en = 1'b1;
          b_res.result_kind = RK_ERROR;
          b_res.error_code = ERR_UNKNOWN;
          b_res.row = lcnt_d;
          b_res.column = p - lbeg_d;
          mode_d = MODE_HALT;
        end
      end
    end

    if (cfg_we_i) begin
      pos_d = cfg_offset_i;
    end
  end

  always_comb begin
    r0 = a_en ? a_res : b_res;
    r1 = b_res;
    r0.last = !(a_en && b_en);
    r1.last = 1'b1;
  end

  assign res0_o  = r0;
  assign res1_o  = r1;
  assign count_o = {1'b0, a_en} + {1'b0, b_en};

endmodule

// File: hdl/source_text_tokenizer.sv
// top level of the source text tokenizer: config register, scanner, result queue
// depends on stt_pkg and stt_scan
//
//   port group    dir   holds
//   s_axis_*      in    item: source byte ch, zero ends the text
//   m_axis_*      out   item: result fields, tlast marks the last one of a byte
//   apb           in    register start_offset at address 0
//
// one byte is taken per cycle while the queue has room; state updates at the accept
// edge and its results enter a four-entry queue in the same edge, shown once
// older results are read; a group, NUL or unknown byte closing a token gives two
// results; s_axis_tready_o is high while the queue has room for two results
// reset clears scanner state, queue and start offset; no clearing pass

module source_text_tokenizer #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  localparam int TdataW = ((8 + 4 * OFFSET_BITS + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // ch
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // result_kind, token_kind, begin_pos, end_pos, error_code, row, column
  output logic [TdataW-1:0] m_axis_tdata_o,
  output logic              m_axis_tlast_o,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);
  import stt_pkg::*;

  localparam int ResW  = 9 + 4 * OFFSET_BITS;
  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  typedef struct packed {
    logic [OFFSET_BITS-1:0] column;
    logic [OFFSET_BITS-1:0] row;
    logic [2:0]             error_code;
    logic [OFFSET_BITS-1:0] end_pos;
    logic [OFFSET_BITS-1:0] begin_pos;
    logic [2:0]             token_kind;
    logic [1:0]             result_kind;
    logic                   last;
  } res_t;

  logic [OFFSET_BITS-1:0] start_q;
  logic                   cfg_we;
  logic                   in_acc, out_acc;
  logic [ResW-1:0]        res0_v, res1_v;
  res_t                   res0, res1, head;
  logic [1:0]             push_n;
  res_t                   queue_q [Depth];
  logic [PtrW-1:0]        wr_q, rd_q;
  logic [CntW-1:0]        cnt_q, cnt_d;

  // config port
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_START_OFFSET);
  assign prdata_o = (paddr_i[2] == REG_START_OFFSET) ? 32'(start_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_we) begin
      start_q <= pwdata_i[OFFSET_BITS-1:0];
    end
  end

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  stt_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_acc),
    .ch_i        (s_axis_tdata_i),
    .cfg_we_i    (cfg_we),
    .cfg_offset_i(pwdata_i[OFFSET_BITS-1:0]),
    .res0_o      (res0_v),
    .res1_o      (res1_v),
    .count_o     (push_n)
  );

  assign res0 = res0_v;
  assign res1 = res1_v;

  // result queue, up to two writes and one read per cycle; a read waits for m_axis_tready_i
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_q + 1'b1] <= res1;
    end
  end

  always_comb begin
    cnt_d = cnt_q + CntW'(push_n) - CntW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_n);
      rd_q  <= rd_q + PtrW'(out_acc);
      cnt_q <= cnt_d;
    end
  end

  assign s_axis_tready_o = (cnt_q <= CntW'(Depth - 2));
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign head            = queue_q[rd_q];
  assign m_axis_tlast_o  = head.last;
  assign m_axis_tdata_o  = TdataW'({head.column, head.row, head.error_code, head.end_pos,
                                    head.begin_pos, head.token_kind, head.result_kind});

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overfilled");

  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |-> push_n == 2'd0)
    else $error("result pushed without an accepted item");

  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n == 2'd1 |-> res0.last)
    else $error("single result lacks last");

  a_last_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n == 2'd2 |-> !res0.last && res1.last)
    else $error("result pair has wrong last marks");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && cnt_q == CntW'(1) && push_n == 2'd0 |=> !m_axis_tvalid_o)
    else $error("queue shows a result after draining");

endmodule
